// ===== design/sts_pkg.sv =====
// shared types, constants and command codes for the serial touch-screen controller
// no dependencies; every other design file refers to this package by scoped names
`timescale 1ns / 1ps

package sts_pkg;

	// fifo depths
	localparam int CMD_DEPTH    = 16;
	localparam int REPORT_DEPTH = 16;
	localparam int QUEUE_DEPTH  = 4;

	localparam int CMD_AW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CMD_CW = $clog2(CMD_DEPTH + 1);
	localparam int REP_AW = (REPORT_DEPTH > 1) ? $clog2(REPORT_DEPTH) : 1;
	localparam int REP_CW = $clog2(REPORT_DEPTH + 1);
	localparam int Q_AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int Q_CW   = $clog2(QUEUE_DEPTH + 1);

	// word kinds
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	// command and report characters
	localparam logic [7:0] CH_MODE    = 8'h4D;
	localparam logic [7:0] CH_ASK     = 8'h3F;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] NIB_BASE   = 8'h40;
	localparam logic [7:0] UNTOUCHED  = 8'h40 + 8'h0F;

	// modes
	localparam logic [15:0] MODE_ASK      = 16'd1;
	localparam logic [15:0] MODE_STREAM_A = 16'd129;
	localparam logic [15:0] MODE_STREAM_B = 16'd130;

	localparam logic [13:0] BUSY_RESET = 14'd8192;

	// position scaling: exact quotient by reciprocal for 16-bit dividends
	localparam logic [15:0] POS_MAX     = 16'hFFFF;
	localparam int          CELL_DIV_X  = 65536 / 120;
	localparam int          CELL_DIV_Y  = 65536 / 90;
	localparam int          RECIP_SHIFT = 26;
	localparam longint      RECIP_X_L   = ((64'd1 << RECIP_SHIFT) + CELL_DIV_X - 1) / CELL_DIV_X;
	localparam longint      RECIP_Y_L   = ((64'd1 << RECIP_SHIFT) + CELL_DIV_Y - 1) / CELL_DIV_Y;
	localparam logic [16:0] RECIP_X     = 17'(RECIP_X_L);
	localparam logic [16:0] RECIP_Y     = 17'(RECIP_Y_L);

	// last byte index of a report
	localparam logic [2:0] RPT_LAST = 3'd4;

	// classified word passed from front to back
	typedef struct packed {
		logic [1:0] func;
		logic [7:0] wbyte;
		logic [6:0] cell_x;
		logic [6:0] cell_y;
		logic [2:0] buttons;
	} op_t;

	// one result word
	typedef struct packed {
		logic       dropped;
		logic       data_waiting;
		logic [7:0] read_data;
	} res_t;

	// back-end status for checking
	typedef struct packed {
		logic emit;
		logic rep_empty;
	} bk_stat_t;

endpackage

// ===== design/sts_front.sv =====
// front end: takes input words, scales the pointer position to cells
// depends on sts_pkg
`timescale 1ns / 1ps

module sts_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [47:0]   s_tdata,   // func, write_byte, pos_x, pos_y, buttons, zero pad
	output logic          q_valid,
	input  logic          q_ready,
	output sts_pkg::op_t  q_data
);

	logic        v_s1;
	logic [1:0]  func_s1;
	logic [7:0]  wbyte_s1;
	logic [15:0] px_s1;
	logic [15:0] py_s1;
	logic [2:0]  btn_s1;

	logic [15:0] dx;
	logic [32:0] prod_x;
	logic [32:0] prod_y;

	assign s_tready = !v_s1 || q_ready;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1 <= 1'b1;
		end else if (q_ready) begin
			v_s1 <= 1'b0;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1  <= s_tdata[1:0];
			wbyte_s1 <= s_tdata[9:2];
			px_s1    <= s_tdata[25:10];
			py_s1    <= s_tdata[41:26];
			btn_s1   <= s_tdata[44:42];
		end
	end

	// cell scaling by reciprocal multiply, x axis mirrored
	assign dx     = sts_pkg::POS_MAX - px_s1;
	assign prod_x = 33'(dx) * 33'(sts_pkg::RECIP_X);
	assign prod_y = 33'(py_s1) * 33'(sts_pkg::RECIP_Y);

	assign q_valid        = v_s1;
	assign q_data.func    = func_s1;
	assign q_data.wbyte   = wbyte_s1;
	assign q_data.cell_x  = prod_x[sts_pkg::RECIP_SHIFT +: 7] + 7'd1;
	assign q_data.cell_y  = prod_y[sts_pkg::RECIP_SHIFT +: 7] + 7'd1;
	assign q_data.buttons = btn_s1;

endmodule

// ===== design/sts_queue.sv =====
// short queue of classified words between front and back
// depends on sts_pkg
`timescale 1ns / 1ps

module sts_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sts_pkg::op_t  in_data,
	output logic          out_valid,
	input  logic          out_pop,
	output sts_pkg::op_t  out_data
);

	sts_pkg::op_t              ent_q [sts_pkg::QUEUE_DEPTH];
	logic [sts_pkg::Q_AW-1:0] head_q;
	logic [sts_pkg::Q_AW-1:0] tail_q;
	logic [sts_pkg::Q_CW-1:0] count_q;
	logic                      push;

	assign in_ready  = count_q != sts_pkg::Q_CW'(sts_pkg::QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign out_data  = ent_q[head_q];
	assign push      = in_valid && in_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == sts_pkg::Q_AW'(sts_pkg::QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (out_pop) begin
				head_q <= (head_q == sts_pkg::Q_AW'(sts_pkg::QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (push && !out_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && out_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[tail_q] <= in_data;
		end
	end

endmodule

// ===== design/sts_back.sv =====
// back end: command and report fifos, mode decoding, busy countdown, report sender
// depends on sts_pkg
`timescale 1ns / 1ps

module sts_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [13:0]       cfg_wdata,
	input  logic              op_valid,
	input  sts_pkg::op_t      op_data,
	output logic              op_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // read_data, data_waiting, dropped, zero pad
	output sts_pkg::bk_stat_t stat
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	logic [1:0] state_q;
	sts_pkg::op_t op_q;

	logic [7:0]                  cmd_mem [sts_pkg::CMD_DEPTH];
	logic [sts_pkg::CMD_AW-1:0]  cmd_head_q;
	logic [sts_pkg::CMD_AW-1:0]  cmd_tail_q;
	logic [sts_pkg::CMD_CW-1:0]  cmd_count_q;
	logic [7:0]                  cmd_rdata_q;

	logic [7:0]                  rep_mem [sts_pkg::REPORT_DEPTH];
	logic [sts_pkg::REP_AW-1:0]  rep_head_q;
	logic [sts_pkg::REP_AW-1:0]  rep_tail_q;
	logic [sts_pkg::REP_CW-1:0]  rep_count_q;
	logic [7:0]                  rep_rdata_q;

	logic [15:0] mode_q;
	logic [13:0] busy_cnt_q;
	logic [13:0] busy_ticks_q;
	logic [6:0]  last_x_q;
	logic [6:0]  last_y_q;
	logic [2:0]  last_btn_q;
	logic        last_valid_q;
	logic [2:0]  push_idx_q;
	logic        drop_q;
	logic        out_valid_q;
	sts_pkg::res_t out_q;

	// decode results
	logic          exec;
	logic          emit;
	sts_pkg::res_t res;
	logic          cmd_push;
	logic          cmd_pop;
	logic          rep_pop;
	logic          load_busy;
	logic          dec_busy;
	logic          start_rpt;
	logic          force_rpt;
	logic          changed;
	logic [15:0]   mode_nx;
	logic [15:0]   mode_x10;
	logic          is_digit;
	logic          rep_room;
	logic          rep_write;
	logic [7:0]    rpt_byte;

	assign exec     = state_q == ST_EXEC;
	assign op_pop   = (state_q == ST_IDLE) && op_valid && (!out_valid_q || m_tready);
	assign rep_room = rep_count_q != sts_pkg::REP_CW'(sts_pkg::REPORT_DEPTH);
	assign rep_write = (state_q == ST_PUSH) && rep_room;
	assign is_digit = (cmd_rdata_q >= sts_pkg::CH_ZERO) && (cmd_rdata_q <= sts_pkg::CH_NINE);
	assign mode_x10 = {mode_q[12:0], 3'b000} + {mode_q[14:0], 1'b0};
	assign changed  = !last_valid_q || (op_q.cell_x != last_x_q) || (op_q.cell_y != last_y_q)
		|| (op_q.buttons != last_btn_q);

	// execute one word
	always_comb begin
		emit      = 1'b0;
		res       = '0;
		cmd_push  = 1'b0;
		cmd_pop   = 1'b0;
		rep_pop   = 1'b0;
		load_busy = 1'b0;
		dec_busy  = 1'b0;
		start_rpt = 1'b0;
		force_rpt = 1'b0;
		mode_nx   = mode_q;
		if (exec) begin
			case (op_q.func)
				sts_pkg::FUNC_WRITE: begin
					emit = 1'b1;
					if (cmd_count_q != sts_pkg::CMD_CW'(sts_pkg::CMD_DEPTH)) begin
						cmd_push  = 1'b1;
						load_busy = 1'b1;
					end else begin
						res.dropped = 1'b1;
					end
				end
				sts_pkg::FUNC_READ: begin
					emit = 1'b1;
					if (rep_count_q != '0) begin
						rep_pop       = 1'b1;
						load_busy     = 1'b1;
						res.read_data = rep_rdata_q;
					end
				end
				sts_pkg::FUNC_TICK: begin
					if (busy_cnt_q != '0) begin
						dec_busy = 1'b1;
						emit     = 1'b1;
					end else if (rep_count_q != '0) begin
						res.data_waiting = 1'b1;
						emit             = 1'b1;
					end else begin
						if (cmd_count_q != '0) begin
							cmd_pop = 1'b1;
							if (cmd_rdata_q == sts_pkg::CH_MODE) begin
								mode_nx = '0;
							end else if (is_digit) begin
								mode_nx = mode_x10 + {12'd0, cmd_rdata_q[3:0]};
							end else if (cmd_rdata_q == sts_pkg::CH_ASK
								&& mode_q == sts_pkg::MODE_ASK) begin
								force_rpt = 1'b1;
							end
						end
						if (force_rpt || (changed && (mode_nx == sts_pkg::MODE_STREAM_A
							|| mode_nx == sts_pkg::MODE_STREAM_B))) begin
							start_rpt = 1'b1;
						end else begin
							emit = 1'b1;
						end
					end
				end
				default: begin
					emit = 1'b1;
				end
			endcase
		end else if (state_q == ST_PUSH && push_idx_q == sts_pkg::RPT_LAST) begin
			emit        = 1'b1;
			res.dropped = drop_q || !rep_room;
		end
	end

	// report byte for the current slot
	always_comb begin
		case (push_idx_q)
			3'd0:    rpt_byte = op_q.buttons[0] ? sts_pkg::NIB_BASE + {5'd0, op_q.cell_x[6:4]}
				: sts_pkg::UNTOUCHED;
			3'd1:    rpt_byte = op_q.buttons[0] ? sts_pkg::NIB_BASE + {4'd0, op_q.cell_x[3:0]}
				: sts_pkg::UNTOUCHED;
			3'd2:    rpt_byte = op_q.buttons[0] ? sts_pkg::NIB_BASE + {5'd0, op_q.cell_y[6:4]}
				: sts_pkg::UNTOUCHED;
			3'd3:    rpt_byte = op_q.buttons[0] ? sts_pkg::NIB_BASE + {4'd0, op_q.cell_y[3:0]}
				: sts_pkg::UNTOUCHED;
			default: rpt_byte = sts_pkg::CH_DOT;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			push_idx_q <= '0;
			drop_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (op_pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					push_idx_q <= '0;
					drop_q     <= 1'b0;
					state_q    <= start_rpt ? ST_PUSH : ST_IDLE;
				end
				ST_PUSH: begin
					push_idx_q <= push_idx_q + 3'd1;
					if (!rep_room) begin
						drop_q <= 1'b1;
					end
					if (push_idx_q == sts_pkg::RPT_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// word under execution
	always_ff @(posedge clk) begin
		if (op_pop) begin
			op_q <= op_data;
		end
	end

	// fifo pointers, mode, countdown and last reported values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_head_q   <= '0;
			cmd_tail_q   <= '0;
			cmd_count_q  <= '0;
			rep_head_q   <= '0;
			rep_tail_q   <= '0;
			rep_count_q  <= '0;
			mode_q       <= '0;
			busy_cnt_q   <= '0;
			busy_ticks_q <= sts_pkg::BUSY_RESET;
			last_x_q     <= '0;
			last_y_q     <= '0;
			last_btn_q   <= '0;
			last_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				busy_ticks_q <= cfg_wdata;
			end
			if (cmd_push) begin
				cmd_tail_q  <= (cmd_tail_q == sts_pkg::CMD_AW'(sts_pkg::CMD_DEPTH - 1))
					? '0 : cmd_tail_q + 1'b1;
				cmd_count_q <= cmd_count_q + 1'b1;
			end
			if (cmd_pop) begin
				cmd_head_q  <= (cmd_head_q == sts_pkg::CMD_AW'(sts_pkg::CMD_DEPTH - 1))
					? '0 : cmd_head_q + 1'b1;
				cmd_count_q <= cmd_count_q - 1'b1;
			end
			if (rep_pop) begin
				rep_head_q  <= (rep_head_q == sts_pkg::REP_AW'(sts_pkg::REPORT_DEPTH - 1))
					? '0 : rep_head_q + 1'b1;
				rep_count_q <= rep_count_q - 1'b1;
			end
			if (rep_write) begin
				rep_tail_q  <= (rep_tail_q == sts_pkg::REP_AW'(sts_pkg::REPORT_DEPTH - 1))
					? '0 : rep_tail_q + 1'b1;
				rep_count_q <= rep_count_q + 1'b1;
			end
			if (load_busy) begin
				busy_cnt_q <= busy_ticks_q;
			end else if (dec_busy) begin
				busy_cnt_q <= busy_cnt_q - 14'd1;
			end
			if (exec) begin
				mode_q <= mode_nx;
			end
			if (start_rpt) begin
				last_x_q     <= op_q.cell_x;
				last_y_q     <= op_q.cell_y;
				last_btn_q   <= op_q.buttons;
				last_valid_q <= 1'b1;
			end
		end
	end

	// fifo storage with registered reads at the heads
	always_ff @(posedge clk) begin
		if (cmd_push) begin
			cmd_mem[cmd_tail_q] <= op_q.wbyte;
		end
		if (rep_write) begin
			rep_mem[rep_tail_q] <= rpt_byte;
		end
		cmd_rdata_q <= cmd_mem[cmd_head_q];
		rep_rdata_q <= rep_mem[rep_head_q];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	assign m_tvalid       = out_valid_q;
	assign m_tdata        = {6'd0, out_q};
	assign stat.emit      = emit;
	assign stat.rep_empty = rep_count_q == '0;

endmodule

// ===== design/serial_touch_screen_controller.sv =====
// a word passes the front stage register and the queue, then the back end's idle and execute
// states and its output register; a word that sends a report also passes a push state for each
// of its five bytes, which go one a cycle through the report fifo write port; the back end
// takes a word only in idle; front accepts a word a cycle while the 4-entry queue has room
// reset: asynchronous, clears fifos, mode, countdown and last values, busy_ticks to 8192
`timescale 1ns / 1ps

module serial_touch_screen_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [13:0] cfg_wdata,   // busy_ticks
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,     // func, write_byte, pos_x, pos_y, buttons, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata      // read_data, data_waiting, dropped, zero pad
);

	logic              fq_valid;
	logic              fq_ready;
	sts_pkg::op_t      fq_data;
	logic              qb_valid;
	logic              qb_pop;
	sts_pkg::op_t      qb_data;
	sts_pkg::bk_stat_t bk_stat;

	// classification and scaling
	sts_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_data   (fq_data)
	);

	// decoupling queue
	sts_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_data   (fq_data),
		.out_valid (qb_valid),
		.out_pop   (qb_pop),
		.out_data  (qb_data)
	);

	// execution
	sts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.op_valid  (qb_valid),
		.op_data   (qb_data),
		.op_pop    (qb_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.stat      (bk_stat)
	);

`ifndef SYNTHESIS
	// back end only takes a word from an occupied queue
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		qb_pop |-> qb_valid)
		else $error("pop from empty queue");

	// a word is taken only when the output register frees up
	a_pop_room: assert property (@(posedge clk) disable iff (!arst_n)
		qb_pop && m_tvalid |-> m_tready)
		else $error("pop while result stalled");

	// a waiting flag on show means report bytes are still held
	a_wait_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8] |-> !bk_stat.rep_empty)
		else $error("data_waiting with empty report fifo");

	// every emitted result appears on the output
	a_emit_out: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.emit |=> m_tvalid)
		else $error("emitted result lost");
`endif

endmodule
